/* design/ise_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_pkg: shared types and constants of the insertion sort engine
// Transfer payloads, the default chain length and the cell link types.
// ----------------------------------------------------------------------------
package ise_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int DATA_W       = 32;

	// Input transfer payload
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last_in;
	} in_item_t;

	// Output transfer payload
	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     last_out;
		logic                     overflowed;
	} out_item_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic                     ins_en;
		logic                     shift_en;
		logic signed [DATA_W-1:0] value;
	} cell_ctrl_t;

	// What a cell shows its neighbors
	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic                     valid;
		logic                     ins;
	} cell_link_t;

endpackage

/* design/ise_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_cell: one compare-and-shift cell of the sorting chain
// Holds one sorted entry. On insert, takes the new value or the left
// neighbor's entry; on drain, takes the right neighbor's entry.
// ----------------------------------------------------------------------------
module ise_cell
	import ise_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  cell_link_t left,
	input  cell_link_t right,
	output cell_link_t link
);

	logic signed [DATA_W-1:0] val_q;
	logic                     valid_q;
	logic                     ins;

	// Insert point: first entry greater than the new value, or empty
	assign ins = !valid_q || (ctrl.value < val_q);

	assign link.val   = val_q;
	assign link.valid = valid_q;
	assign link.ins   = ins;

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift_en) begin
			valid_q <= right.valid;
		end else if (ctrl.ins_en && ins) begin
			valid_q <= left.ins ? left.valid : 1'b1;
		end
	end

	// Hold the entry value
	always_ff @(posedge clk) begin
		if (ctrl.shift_en) begin
			val_q <= right.val;
		end else if (ctrl.ins_en && ins) begin
			val_q <= left.ins ? left.val : ctrl.value;
		end
	end

endmodule

/* design/insertion_sort_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sort_engine_unit: streaming insertion sort of signed values
// Sorts a set of up to CAPACITY values in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: one signed value per transfer; last_in closes the set.
//   Each accepted value is inserted into the chain in the same cycle, after
//   any equal values, so the input takes one item per cycle while filling.
//   Values arriving while all CAPACITY cells are full are dropped and the
//   set is marked overflowed.
//   result channel: after the last item, the chain drains toward cell 0 one
//   entry per result transfer, ascending, with last_out on the final one and
//   overflowed on every result of the set. The first result is valid in the
//   cycle after the last item is accepted.
//   item_stall is high during the drain: the chain serves one set at a time.
//   A stall on the result channel freezes the chain, and the shown result
//   holds until it is taken.
//   Reset empties the chain and clears the overflow flag; no sweep follows.
// ----------------------------------------------------------------------------
module insertion_sort_engine_unit
	import ise_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	cell_link_t            links [CAPACITY];
	logic [CAPACITY-1:0]   cell_valid;
	cell_ctrl_t            ctrl;
	logic                  draining_q;
	logic                  overflow_q;
	logic                  item_xfer;
	logic                  result_xfer;
	logic                  full;

	assign full         = cell_valid[CAPACITY-1];
	assign item_stall   = draining_q;
	assign item_xfer    = item_valid && !draining_q;
	assign result_valid = draining_q && cell_valid[0];
	assign result_xfer  = result_valid && !result_stall;

	// Broadcast insert or drain to every cell
	assign ctrl.ins_en   = item_xfer && !full;
	assign ctrl.shift_en = result_xfer;
	assign ctrl.value    = item.value;

	// Drive the result from the head cell
	assign result.sorted_value = links[0].val;
	assign result.last_out     = !cell_valid[1];
	assign result.overflowed   = overflow_q;

	// Build the chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_link_t left_link;
		cell_link_t right_link;

		if (i == 0) begin : g_head
			assign left_link = '0;
		end else begin : g_left
			assign left_link = links[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_link = '0;
		end else begin : g_right
			assign right_link = links[i+1];
		end

		ise_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.left   (left_link),
			.right  (right_link),
			.link   (links[i])
		);

		assign cell_valid[i] = links[i].valid;
	end

	// Sequence fill and drain, track overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			overflow_q <= 1'b0;
		end else begin
			if (item_xfer && item.last_in) begin
				draining_q <= 1'b1;
			end else if (result_xfer && result.last_out) begin
				draining_q <= 1'b0;
			end

			if (item_xfer && full) begin
				overflow_q <= 1'b1;
			end else if (result_xfer && result.last_out) begin
				overflow_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// Occupied cells always form a run starting at cell 0
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_valid & (cell_valid + CAPACITY'(1))) == '0)
		else $error("chain occupancy has a gap");

	// The final result leaves the chain empty
	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(result_xfer && result.last_out) |=> (cell_valid == '0 && !overflow_q))
		else $error("chain not empty after final result");

	// An accepted item other than the last while full marks the set overflowed
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(item_xfer && full && !item.last_in) |=> overflow_q)
		else $error("dropped value not flagged");

	// A drain always starts with at least one entry
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(item_xfer && item.last_in) |=> result_valid)
		else $error("drain started with an empty chain");
`endif

endmodule
